// ===== rtl/core/b85enc_pkg.sv =====
// ----------------------------------------------------------------------------
// b85enc_pkg
// Shared types and constants for the base-85 stream encoder: the control word
// of the microprogram, the status fed back to the sequencer, and the
// arithmetic constants of the digit conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package b85enc_pkg;

	localparam int unsigned ByteW     = 8;
	localparam int unsigned GroupW    = 32;
	localparam int unsigned CharW     = 7;
	localparam int unsigned DigitW    = 7;
	localparam int unsigned QuotW     = 26;   // floor((2^32-1)/85) fits in 26 bits
	localparam int unsigned NumDigits = 5;
	localparam int unsigned StepW     = 2;

	localparam logic [31:0] Recip85   = 32'd3233857729;
	localparam int unsigned RecipSh   = 38;
	localparam logic [6:0]  Base85    = 7'd85;
	localparam logic [6:0]  CharBias  = 7'd33;   // '!'

	// Jump conditions of the microprogram. When the condition is true the
	// sequencer goes to the word's target, otherwise to the next step.
	typedef enum logic [1:0] {
		COND_NEVER      = 2'd0,
		COND_NO_GROUP   = 2'd1,   // no transfer that completes a group
		COND_MORE_DIGIT = 2'd2,   // conversion loop not yet at the fifth digit
		COND_MORE_EMIT  = 2'd3    // last character not yet loaded
	} cond_t;

	typedef struct packed {
		logic  take;     // accept input bytes
		logic  mul;      // reciprocal multiply of the group word
		logic  rem;      // remainder, digit shift-in, quotient write-back
		logic  emit;     // load characters into the output register
		cond_t cond;
		logic [StepW-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic group_fire;    // byte accepted that closes a group
		logic digit_last;    // fifth digit is being produced
		logic emit_last;     // final character is being loaded
	} stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/b85enc_ucode.sv =====
// ----------------------------------------------------------------------------
// b85enc_ucode
// Microprogram store and step counter. Each step reads one control word from
// a constant table and picks the next step from the word's jump condition.
// ----------------------------------------------------------------------------
`default_nettype none

module b85enc_ucode (
	input  wire                 clk,
	input  wire                 arst_n,
	input  b85enc_pkg::stat_t   stat,
	output b85enc_pkg::ctrl_t   ctrl
);
	import b85enc_pkg::*;

	localparam int unsigned NumSteps = 2 ** StepW;

	// Step 0 waits for bytes, steps 1 and 2 form the divide loop, step 3
	// drains the digits. The step counter wraps from 3 back to 0.
	localparam ctrl_t Program [NumSteps] = '{
		'{take: 1'b1, mul: 1'b0, rem: 1'b0, emit: 1'b0,
		  cond: COND_NO_GROUP,   target: StepW'(0)},
		'{take: 1'b0, mul: 1'b1, rem: 1'b0, emit: 1'b0,
		  cond: COND_NEVER,      target: StepW'(0)},
		'{take: 1'b0, mul: 1'b0, rem: 1'b1, emit: 1'b0,
		  cond: COND_MORE_DIGIT, target: StepW'(1)},
		'{take: 1'b0, mul: 1'b0, rem: 1'b0, emit: 1'b1,
		  cond: COND_MORE_EMIT,  target: StepW'(3)}
	};

	logic [StepW-1:0] step_q;
	logic             jump;

	assign ctrl = Program[step_q];

	always_comb begin
		case (ctrl.cond)
			COND_NEVER:      jump = 1'b0;
			COND_NO_GROUP:   jump = !stat.group_fire;
			COND_MORE_DIGIT: jump = !stat.digit_last;
			COND_MORE_EMIT:  jump = !stat.emit_last;
			default:         jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (jump) begin
			step_q <= ctrl.target;
		end else begin
			step_q <= step_q + StepW'(1);
		end
	end

	// Exactly one datapath action is enabled in every step.
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({ctrl.take, ctrl.mul, ctrl.rem, ctrl.emit}))
		else $error("control word enables more or less than one action");

	// A closing byte always starts the conversion loop.
	a_fire_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.take && stat.group_fire |=> ctrl.mul)
		else $error("closed group did not enter the multiply step");

	// The drain step is entered only from the end of the conversion loop.
	a_emit_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ctrl.emit) |-> $past(ctrl.rem && stat.digit_last))
		else $error("drain step entered without a finished conversion");

endmodule

`default_nettype wire

// ===== rtl/core/b85enc_datapath.sv =====
// ----------------------------------------------------------------------------
// b85enc_datapath
// Group register, reciprocal divider by 85, digit shift register and the
// output register, each enabled by the current control word.
// ----------------------------------------------------------------------------
`default_nettype none

module b85enc_datapath (
	input  wire                     clk,
	input  wire                     arst_n,
	input  b85enc_pkg::ctrl_t       ctrl,
	output b85enc_pkg::stat_t       stat,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire [7:0]               in_byte,
	input  wire                     in_eos,
	output logic                    out_valid,
	input  wire                     out_ready,
	output logic [6:0]              out_char,
	output logic                    out_last,
	output logic                    out_done
);
	import b85enc_pkg::*;

	logic [GroupW-1:0] group_q;
	logic [1:0]        held_q;
	logic [2:0]        n_q;
	logic              eos_q;
	logic [2:0]        cnt_q;
	logic [QuotW-1:0]  quot_q;
	logic [DigitW-1:0] dig_q [NumDigits];
	logic              out_valid_q;
	logic [CharW-1:0]  out_char_q;
	logic              out_last_q;
	logic              out_done_q;

	logic              fire;
	logic              closes;
	logic [GroupW-1:0] merged;
	logic [63:0]       product;
	logic [GroupW-1:0] rem_full;
	logic              load;
	logic              is_last;

	assign in_ready = ctrl.take;
	assign fire     = in_valid && ctrl.take;
	assign closes   = (held_q == 2'd3) || in_eos;
	// Byte k of the group goes to bits 31-8k (big-endian).
	assign merged   = group_q | (GroupW'(in_byte) << {~held_q, 3'b000});

	assign product  = 64'(group_q) * 64'(Recip85);
	assign rem_full = group_q - (GroupW'(quot_q) * GroupW'(Base85));

	assign is_last  = (cnt_q == (n_q - 3'd1));
	assign load     = ctrl.emit && (!out_valid_q || out_ready);

	assign stat.group_fire = fire && closes;
	assign stat.digit_last = (cnt_q == 3'(NumDigits - 1));
	assign stat.emit_last  = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q     <= '0;
			held_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				group_q <= merged;
				held_q  <= closes ? 2'd0 : held_q + 2'd1;
			end else if (ctrl.rem) begin
				// Five divisions by 85 take any 32-bit word to zero.
				group_q <= GroupW'(quot_q);
			end

			if (ctrl.rem) begin
				cnt_q <= stat.digit_last ? 3'd0 : cnt_q + 3'd1;
			end else if (load) begin
				cnt_q <= is_last ? 3'd0 : cnt_q + 3'd1;
			end

			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && closes) begin
			n_q   <= (held_q == 2'd3) ? 3'd5 : 3'(held_q) + 3'd2;
			eos_q <= in_eos;
		end
		if (ctrl.mul) begin
			quot_q <= product[RecipSh +: QuotW];
		end
		// Digits arrive least significant first; the newest sits at index 0,
		// so after the loop index 0 holds the most significant digit.
		if (ctrl.rem) begin
			dig_q[0] <= rem_full[DigitW-1:0];
			for (int i = 1; i < NumDigits; i++) begin
				dig_q[i] <= dig_q[i-1];
			end
		end else if (load) begin
			for (int i = 0; i < NumDigits - 1; i++) begin
				dig_q[i] <= dig_q[i+1];
			end
		end
		if (load) begin
			out_char_q <= dig_q[0] + CharBias;
			out_last_q <= is_last;
			out_done_q <= eos_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;
	assign out_done  = out_done_q;

	a_group_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rem && stat.digit_last |=> group_q == '0)
		else $error("group word not zero after the fifth division");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_char_q >= 7'd33) && (out_char_q <= 7'd117))
		else $error("character outside the base-85 alphabet");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> (n_q >= 3'd2) && (n_q <= 3'd5))
		else $error("character count out of range while draining");

endmodule

`default_nettype wire

// ===== rtl/core/base85_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// base85_stream_encoder
// Byte-stream base-85 encoder: packs bytes big-endian into 32-bit groups and
// writes each group as five characters '!'..'u', most significant first.
// A byte that closes a group starts the conversion; its characters then follow
// one per cycle while the receiver is ready.
// Throughput: one byte per cycle while a group fills; a closing byte stalls
// the input through the five passes of the shared multiply/remainder loop
// and until the last character of its group enters the output register.
// Reset clears the sequencer, the partial group and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module base85_stream_encoder (
	input  wire        clk,
	input  wire        arst_n,
	// Input stream.
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire  [7:0] s_axis_tdata,   // [7:0] data_byte
	input  wire        s_axis_tlast,   // end_of_stream
	// Output stream.
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
	output logic       m_axis_tlast,   // last_of_run
	output logic       m_axis_tuser    // [0] stream_done
);
	import b85enc_pkg::*;

	ctrl_t      ctrl;
	stat_t      stat;
	logic [6:0] out_char;

	// The sequencer runs a four-step program: collect bytes, then multiply
	// and remainder five times, then drain the digits into the output
	// register. A partial group at end of stream is converted the same way
	// with zero padding, and only the leading count+1 characters are sent.
	b85enc_ucode u_ucode (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// The output register decouples the two sides, so the next byte transfer
	// is taken while the last character of a group still waits downstream.
	b85enc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_eos    (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_last  (m_axis_tlast),
		.out_done  (m_axis_tuser)
	);

	assign m_axis_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for base85_stream_encoder. A driver feeds bytes from a
// queue of pending transfers and a monitor predicts the characters of every
// accepted byte, then compares each output transfer with the oldest one due.
// Both sides idle at random, and one long receiver hold-off backs up the core.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ClkHalf    = 5;
	localparam int ResetLen   = 9;
	localparam int LongHold   = 400;   // receiver hold-off that fills the core
	localparam int QuietLimit = 2500;  // cycles with no transfer on either side
	localparam int DrainWait  = 32;    // closing byte latency plus five characters
	localparam int RandItems  = 330;
	localparam logic [6:0] DigitBase = 7'd85;
	localparam logic [6:0] CharBias  = 7'd33;

	typedef enum logic {RX_STEADY, RX_RANDOM} rx_mode_t;
	typedef enum logic {GAPS_NONE, GAPS_RANDOM} gap_mode_t;

	// One input transfer with the idle cycles the driver inserts after it.
	typedef struct {
		logic [7:0] data;
		logic       eos;
		int         gap;
	} byte_item_t;

	// One encoded character as it should leave the core.
	typedef struct packed {
		logic [6:0] ch;
		logic       last;
		logic       done;
	} b85_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_valid = 1'b0;
	logic       s_ready;
	logic [7:0] s_data = 8'd0;    // [7:0] data_byte
	logic       s_last = 1'b0;    // end_of_stream
	logic       m_valid;
	logic       m_ready = 1'b0;
	logic [7:0] m_data;           // [6:0] out_char, [7] zero
	logic       m_last;           // last_of_run
	logic       m_user;           // [0] stream_done

	byte_item_t byte_queue[$];
	b85_char_t  char_queue[$];

	// Predictor state: the partial group and how many bytes it holds.
	logic [31:0] group_acc = 32'd0;
	int          group_fill = 0;

	logic      in_taken = 1'b0;
	int        gap_left = 0;
	int        hold_left = 0;
	int        squeeze_asked = 0;
	int        squeeze_seen = 0;
	rx_mode_t  rx_mode = RX_STEADY;
	int        fail_count = 0;
	int        quiet_cycles = 0;
	int        rand_sent = 0;

	base85_stream_encoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tlast  (s_last),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tlast  (m_last),
		.m_axis_tuser  (m_user)
	);

	always #(ClkHalf) clk = ~clk;

	// Idle lengths: mostly none, often a few cycles, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Adds one accepted byte to the group. A byte that closes the group, either
	// as its fourth byte or as the end of the stream, queues the characters:
	// five for a full group, one more than the byte count for a short one.
	// Short groups are zero padded, which the accumulator already is.
	function automatic void encode_byte(input logic [7:0] b, input logic eos);
		logic [31:0] v;
		logic [6:0]  digit [5];
		b85_char_t   c;
		int          n;
		group_acc = group_acc | ({24'd0, b} << (24 - 8 * group_fill));
		if (group_fill < 3 && !eos) begin
			group_fill++;
			return;
		end
		v = group_acc;
		for (int k = 4; k >= 0; k--) begin
			digit[k] = 7'(v % DigitBase);
			v = v / DigitBase;
		end
		n = (group_fill == 3) ? 5 : group_fill + 2;
		for (int k = 0; k < n; k++) begin
			c.ch = digit[k] + CharBias;
			c.last = (k == n - 1);
			c.done = eos;
			char_queue = {char_queue, c};
		end
		group_acc = 32'd0;
		group_fill = 0;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic eos, input int gap);
		byte_item_t it;
		it.data = b;
		it.eos = eos;
		it.gap = gap;
		byte_queue = {byte_queue, it};
	endtask

	// A whole stream of random bytes, end of stream on the final one. Most
	// streams are short so that every group remainder comes up often.
	task automatic push_stream(input int len, input gap_mode_t gm);
		for (int i = 0; i < len; i++)
			push_byte(8'($urandom_range(0, 255)), i == len - 1,
				gm == GAPS_RANDOM ? idle_len() : 0);
		rand_sent += len;
	endtask

	function automatic int stream_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 12);
		return $urandom_range(13, 40);
	endfunction

	task automatic wait_sent();
		while (byte_queue.size() != 0)
			@(posedge clk);
	endtask

	// Driver: a new transfer is offered only once the previous one went through
	// or the bus was idle, so tvalid never drops while a byte waits.
	always @(negedge clk) begin
		if (arst_n && (!s_valid || in_taken)) begin
			if (gap_left > 0) begin
				s_valid <= 1'b0;
				s_data <= 8'($urandom_range(0, 255));
				s_last <= 1'($urandom_range(0, 1));
				gap_left <= gap_left - 1;
			end else if (byte_queue.size() > 0) begin
				s_valid <= 1'b1;
				s_data <= byte_queue[0].data;
				s_last <= byte_queue[0].eos;
				gap_left <= byte_queue[0].gap;
			end else begin
				s_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, or none at all in steady mode. A squeeze request
	// from the stimulus starts one long hold-off counted here.
	always @(negedge clk) begin
		if (arst_n) begin
			if (squeeze_seen != squeeze_asked) begin
				squeeze_seen <= squeeze_asked;
				hold_left <= LongHold;
				m_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_ready <= 1'b0;
			end else if (rx_mode == RX_STEADY || $urandom_range(0, 99) < 70) begin
				m_ready <= 1'b1;
			end else begin
				m_ready <= 1'b0;
				hold_left <= idle_len();
			end
		end
	end

	// Monitor: an input transfer feeds the predictor before the output side is
	// checked, so an expectation always exists before its character can show.
	always @(posedge clk) begin
		b85_char_t want;
		if (arst_n) begin
			in_taken <= s_valid && s_ready;
			if (s_valid && s_ready) begin
				encode_byte(s_data, s_last);
				if (byte_queue.size() > 0)
					void'(byte_queue.pop_front());
			end
			if (m_valid && m_ready) begin
				if (char_queue.size() == 0) begin
					$error("unexpected character transfer: tdata %0h", m_data);
					fail_count++;
				end else begin
					want = char_queue.pop_front();
					if (m_data[6:0] !== want.ch) begin
						$error("out_char: expected %0d, actual %0d", want.ch, m_data[6:0]);
						fail_count++;
					end
					if (m_data[7] !== 1'b0) begin
						$error("tdata pad bit: expected 0, actual %b", m_data[7]);
						fail_count++;
					end
					if (m_last !== want.last) begin
						$error("last_of_run: expected %b, actual %b", want.last, m_last);
						fail_count++;
					end
					if (m_user !== want.done) begin
						$error("stream_done: expected %b, actual %b", want.done, m_user);
						fail_count++;
					end
				end
			end
		end
	end

	// Watchdog: a stuck handshake on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_valid && s_ready) || (m_valid && m_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QuietLimit) begin
				$display("base85_stream_encoder regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (ResetLen) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, receiver always ready.
		// A full zero group closed by end of stream: five '!' characters.
		push_byte(8'h00, 1'b0, 0);
		push_byte(8'h00, 1'b0, 0);
		push_byte(8'h00, 1'b0, 0);
		push_byte(8'h00, 1'b1, 0);
		// All ones: one group mid-stream, then the same group ends the stream.
		for (int i = 0; i < 8; i++)
			push_byte(8'hFF, i == 7, 0);
		// 85^4 - 2 gives a leading '!', three 'u' and a final 't'; then a lone closing byte.
		push_byte(8'h03, 1'b0, 0);
		push_byte(8'h1C, 1'b0, 0);
		push_byte(8'h84, 1'b0, 0);
		push_byte(8'hAF, 1'b0, 0);
		push_byte(8'h00, 1'b1, 0);
		// Short final groups of one, two and three bytes.
		push_byte(8'hFF, 1'b1, 0);
		push_byte(8'hFF, 1'b0, 0);
		push_byte(8'hFF, 1'b1, 0);
		push_byte(8'h80, 1'b0, 0);
		push_byte(8'h01, 1'b0, 0);
		push_byte(8'h7F, 1'b1, 0);
		wait_sent();

		// Random streams with idling on both sides, some stretches without.
		rx_mode = RX_RANDOM;
		while (rand_sent < RandItems / 2)
			push_stream(stream_len(), $urandom_range(0, 3) == 0 ? GAPS_NONE : GAPS_RANDOM);
		wait_sent();

		// Long receiver hold-off while bytes keep coming back to back.
		squeeze_asked++;
		push_stream(24, GAPS_NONE);
		wait_sent();

		// No idling anywhere for a stretch.
		rx_mode = RX_STEADY;
		while (rand_sent < RandItems * 2 / 3)
			push_stream(stream_len(), GAPS_NONE);
		wait_sent();

		rx_mode = RX_RANDOM;
		while (rand_sent < RandItems)
			push_stream(stream_len(), GAPS_RANDOM);
		wait_sent();

		while (char_queue.size() != 0)
			@(posedge clk);
		repeat (DrainWait) @(posedge clk);
		if (fail_count == 0)
			$display("base85_stream_encoder regression: pass");
		else
			$display("base85_stream_encoder regression: fail");
		$finish;
	end

endmodule
